// ===== src/chained_hash_set_top_assert.svh =====
// ----------------------------------------------------------------------------
// chained_hash_set_top_assert.svh
// assertion macros for the chained hash set, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_TOP_ASSERT_SVH
`define CHAINED_HASH_SET_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CHS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// sizes, types, codes and divider constants of the chained hash set
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

	localparam int BUCKETS   = 10;
	localparam int POOL_SIZE = 64;
	localparam int KEY_BITS  = 16;

	localparam int LINK_W   = $clog2(POOL_SIZE + 1);
	localparam int ADDR_W   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int KEY_IN_W = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;
	localparam int S_DATA_W = ((KEY_IN_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((STATUS_W + COUNT_W + 7) / 8) * 8;
	localparam int M_PAD_W  = M_DATA_W - STATUS_W - COUNT_W;

	// key / BUCKETS as a multiply by a rounded-up reciprocal, exact for every key
	localparam int DIV_SHIFT = KEY_BITS + $clog2(BUCKETS);
	localparam int MULT_W    = KEY_BITS + 1;
	localparam int PROD_W    = KEY_BITS + MULT_W;
	localparam logic [63:0] DIV_MULT_FULL =
		((64'd1 << DIV_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [LINK_W-1:0]   link_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [BKT_W-1:0]    bkt_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [MULT_W-1:0]   mult_t;
	typedef logic [PROD_W-1:0]   prod_t;
	typedef logic [M_PAD_W-1:0]  mpad_t;

	localparam mult_t DIV_MULT = mult_t'(DIV_MULT_FULL);
	localparam link_t NIL_LINK = link_t'(POOL_SIZE);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_PRESENT   = 3'd1;
	localparam status_t ST_POOL_FULL = 3'd2;
	localparam status_t ST_DELETED   = 3'd3;
	localparam status_t ST_NOT_FOUND = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_REM,
		S_HEAD,
		S_WALK,
		S_FIN,
		S_ALLOC,
		S_LINK,
		S_FREE,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== src/chs_ram.sv =====
// ----------------------------------------------------------------------------
// chs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/chained_hash_set_top.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set_top
// set of keys in a hash table with sorted separate chains over a node pool
// ----------------------------------------------------------------------------
// A beat on the slave side carries one command: tuser[0] selects insert (0) or
// delete (1), tdata[15:0] holds the key. Each command gives exactly one result
// beat on the master side: tdata[2:0] is the status (0 inserted, 1 already
// present, 2 pool full, 3 deleted, 4 not found) and tdata[9:3] the number of
// keys held afterwards. The bucket is key mod 10, found with a reciprocal
// multiply in the S_DIV and S_REM states. The chain walk then reads one node
// per cycle from the node key and node link rams through their shared read
// port, stepping over at most 64 chain nodes. An insert that links a new node
// goes on through S_ALLOC and S_LINK, a delete that unlinks its key through
// S_FREE, and a command that leaves the table alone (duplicate, pool full, not
// found) goes straight to S_OUT. The result loads and the block goes back to
// idle on the same edge, so the next command can be taken in the cycle after;
// a stalled output register keeps the block in S_OUT until the result loads.
// The block takes one command at a time. The result sits in an output
// register, so a new command is taken while an earlier result still waits.
// No clearing pass is needed after reset: pool nodes that were never handed
// out are tracked by a high-water mark and read as linking to the next pool node.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_hash_set_top_assert.svh"

module chained_hash_set_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [chs_pkg::S_DATA_W-1:0] s_tdata,   // key
	input  logic [0:0]                   s_tuser,   // cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [chs_pkg::M_DATA_W-1:0] m_tdata    // status, stored_count, zero pad
);

	// sequencer
	chs_pkg::state_t state_q, state_d;

	// command under work
	logic            cmd_q;
	chs_pkg::key_t   key_q;
	chs_pkg::prod_t  prod_q;
	chs_pkg::bkt_t   bucket_q;

	// chain walk
	chs_pkg::link_t  cur_q;
	chs_pkg::link_t  prev_q;
	chs_pkg::link_t  steps_q;
	logic            found_q;
	chs_pkg::link_t  curnext_q;
	chs_pkg::link_t  alloc_q;
	chs_pkg::status_t res_status_q;

	// table state
	chs_pkg::link_t  bucket_head_q [chs_pkg::BUCKETS];
	chs_pkg::link_t  free_head_q;
	chs_pkg::link_t  hwm_q;          // nodes at or above this were never handed out
	chs_pkg::link_t  key_count_q;

	// output register
	logic             m_tvalid_q;
	chs_pkg::status_t m_status_q;
	chs_pkg::count_t  m_count_q;

	// ram ports
	chs_pkg::addr_t  rd_addr;
	chs_pkg::addr_t  rd_addr_q;      // address behind the current ram read data
	chs_pkg::key_t   ram_key;
	chs_pkg::link_t  ram_next;
	logic            key_we;
	logic            next_we;
	chs_pkg::addr_t  next_wa;
	chs_pkg::link_t  next_wd;

	// datapath
	chs_pkg::prod_t  quot_full;
	chs_pkg::key_t   quot;
	chs_pkg::key_t   rem_full;
	chs_pkg::link_t  head_sel;
	chs_pkg::link_t  rd_next_eff;
	logic            cur_live;
	logic            prev_live;
	logic            key_hit;
	logic            key_gt;
	logic            walk_more;
	logic            free_empty;
	logic            out_load;

	// node key store, reset value undefined
	chs_ram #(
		.WIDTH(chs_pkg::KEY_BITS),
		.DEPTH(chs_pkg::POOL_SIZE)
	) u_node_key (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (chs_pkg::addr_t'(free_head_q)),
		.wr_data (key_q),
		.rd_addr (rd_addr),
		.rd_data (ram_key)
	);

	// node link store, untouched entries are overridden by the high-water mark
	chs_ram #(
		.WIDTH(chs_pkg::LINK_W),
		.DEPTH(chs_pkg::POOL_SIZE)
	) u_node_next (
		.clk     (clk),
		.wr_en   (next_we),
		.wr_addr (next_wa),
		.wr_data (next_wd),
		.rd_addr (rd_addr),
		.rd_data (ram_next)
	);

	// bucket = key - floor(key / BUCKETS) * BUCKETS
	assign quot_full = prod_q >> chs_pkg::DIV_SHIFT;
	assign quot      = chs_pkg::key_t'(quot_full);
	assign rem_full  = key_q - chs_pkg::key_t'(quot * chs_pkg::key_t'(chs_pkg::BUCKETS));

	assign head_sel = bucket_head_q[bucket_q];

	// a never-allocated node still links to the next pool node
	assign rd_next_eff = (chs_pkg::link_t'(rd_addr_q) >= hwm_q)
		? chs_pkg::link_t'(rd_addr_q) + chs_pkg::link_t'(1) : ram_next;

	assign cur_live   = cur_q < chs_pkg::NIL_LINK;
	assign prev_live  = prev_q < chs_pkg::NIL_LINK;
	assign key_hit    = ram_key == key_q;
	assign key_gt     = key_q > ram_key;
	assign free_empty = free_head_q >= chs_pkg::NIL_LINK;
	assign walk_more  = cur_live && (steps_q < chs_pkg::link_t'(chs_pkg::POOL_SIZE))
		&& ((cmd_q == chs_pkg::CMD_INSERT) ? key_gt : !key_hit);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chs_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = chs_pkg::S_DIV;
				end
			end
			chs_pkg::S_DIV:  state_d = chs_pkg::S_REM;
			chs_pkg::S_REM:  state_d = chs_pkg::S_HEAD;
			chs_pkg::S_HEAD: state_d = chs_pkg::S_WALK;
			chs_pkg::S_WALK: begin
				if (!walk_more) begin
					state_d = chs_pkg::S_FIN;
				end
			end
			chs_pkg::S_FIN: begin
				if (cmd_q == chs_pkg::CMD_INSERT) begin
					state_d = (found_q || free_empty) ? chs_pkg::S_OUT : chs_pkg::S_ALLOC;
				end else begin
					state_d = found_q ? chs_pkg::S_FREE : chs_pkg::S_OUT;
				end
			end
			chs_pkg::S_ALLOC: state_d = chs_pkg::S_LINK;
			chs_pkg::S_LINK:  state_d = chs_pkg::S_OUT;
			chs_pkg::S_FREE:  state_d = chs_pkg::S_OUT;
			chs_pkg::S_OUT: begin
				if (out_load) begin
					state_d = chs_pkg::S_IDLE;
				end
			end
			default: state_d = chs_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: ram read address, ram writes, handshakes
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		rd_addr  = chs_pkg::addr_t'(cur_q);
		key_we   = 1'b0;
		next_we  = 1'b0;
		next_wa  = chs_pkg::addr_t'(cur_q);
		next_wd  = free_head_q;
		unique case (state_q)
			chs_pkg::S_IDLE: s_tready = 1'b1;
			chs_pkg::S_HEAD: rd_addr = chs_pkg::addr_t'(head_sel);
			chs_pkg::S_WALK: rd_addr = chs_pkg::addr_t'(rd_next_eff);
			chs_pkg::S_FIN: begin
				// fetch the link of the free head for a possible allocation
				rd_addr = chs_pkg::addr_t'(free_head_q);
				// delete: bypass the found node
				next_we = (cmd_q == chs_pkg::CMD_DELETE) && found_q && prev_live;
				next_wa = chs_pkg::addr_t'(prev_q);
				next_wd = curnext_q;
			end
			chs_pkg::S_ALLOC: begin
				key_we  = 1'b1;
				next_we = 1'b1;
				next_wa = chs_pkg::addr_t'(free_head_q);
				next_wd = cur_q;
			end
			chs_pkg::S_LINK: begin
				next_we = prev_live;
				next_wa = chs_pkg::addr_t'(prev_q);
				next_wd = alloc_q;
			end
			chs_pkg::S_FREE: begin
				next_we = 1'b1;
				next_wa = chs_pkg::addr_t'(cur_q);
				next_wd = free_head_q;
			end
			chs_pkg::S_OUT: out_load = !m_tvalid_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chs_pkg::S_IDLE;
			free_head_q <= '0;
			hwm_q       <= '0;
			key_count_q <= '0;
			m_tvalid_q  <= 1'b0;
			for (int i = 0; i < chs_pkg::BUCKETS; i++) begin
				bucket_head_q[i] <= chs_pkg::NIL_LINK;
			end
		end else begin
			state_q <= state_d;

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				chs_pkg::S_FIN: begin
					if ((cmd_q == chs_pkg::CMD_DELETE) && found_q && !prev_live) begin
						bucket_head_q[bucket_q] <= curnext_q;
					end
				end
				chs_pkg::S_ALLOC: begin
					free_head_q <= rd_next_eff;
					key_count_q <= key_count_q + chs_pkg::link_t'(1);
					if (free_head_q == hwm_q) begin
						hwm_q <= hwm_q + chs_pkg::link_t'(1);
					end
				end
				chs_pkg::S_LINK: begin
					if (!prev_live) begin
						bucket_head_q[bucket_q] <= alloc_q;
					end
				end
				chs_pkg::S_FREE: begin
					free_head_q <= cur_q;
					if (key_count_q != '0) begin
						key_count_q <= key_count_q - chs_pkg::link_t'(1);
					end
				end
				default: begin
					free_head_q <= free_head_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;

		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser[0];
			key_q <= chs_pkg::key_t'(s_tdata[chs_pkg::KEY_IN_W-1:0]);
		end

		case (state_q)
			chs_pkg::S_DIV: prod_q <= chs_pkg::prod_t'(key_q) * chs_pkg::prod_t'(chs_pkg::DIV_MULT);
			chs_pkg::S_REM: bucket_q <= chs_pkg::bkt_t'(rem_full);
			chs_pkg::S_HEAD: begin
				cur_q   <= head_sel;
				prev_q  <= chs_pkg::NIL_LINK;
				steps_q <= '0;
			end
			chs_pkg::S_WALK: begin
				if (walk_more) begin
					prev_q  <= cur_q;
					cur_q   <= rd_next_eff;
					steps_q <= steps_q + chs_pkg::link_t'(1);
				end else begin
					found_q   <= cur_live && key_hit;
					curnext_q <= rd_next_eff;
				end
			end
			chs_pkg::S_FIN: begin
				if (cmd_q == chs_pkg::CMD_INSERT) begin
					res_status_q <= found_q ? chs_pkg::ST_PRESENT
						: (free_empty ? chs_pkg::ST_POOL_FULL : chs_pkg::ST_INSERTED);
				end else begin
					res_status_q <= found_q ? chs_pkg::ST_DELETED : chs_pkg::ST_NOT_FOUND;
				end
			end
			chs_pkg::S_ALLOC: alloc_q <= free_head_q;
			default: begin
				alloc_q <= alloc_q;
			end
		endcase

		if (out_load) begin
			m_status_q <= res_status_q;
			m_count_q  <= chs_pkg::count_t'(key_count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {chs_pkg::mpad_t'(0), m_count_q, m_status_q};

	// the free list runs dry exactly when the pool is fully used
	`CHS_ASSERT_SAME(a_full_matches_count, 1'b1, (free_head_q == chs_pkg::NIL_LINK) == (key_count_q == chs_pkg::link_t'(chs_pkg::POOL_SIZE)), "free list and key count disagree")
	// the free head is a recycled node or the first never-used one
	`CHS_ASSERT_SAME(a_free_below_hwm, 1'b1, free_head_q <= hwm_q, "free head above high-water mark")
	// the high-water mark only grows
	`CHS_ASSERT_NEXT(a_hwm_grows, 1'b1, hwm_q >= $past(hwm_q), "high-water mark went down")
	// an accepted beat starts the bucket computation
	`CHS_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_q == chs_pkg::S_DIV, "accepted beat not started")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chained hash set
// ----------------------------------------------------------------------------
// Sends insert and delete commands on the slave stream and tracks the set of
// held keys in a behavioral model. Each result beat is checked in order
// against the model. The run covers sorted chain edits, duplicate and absent
// keys, a full pool, a single chain that holds the whole pool, a long output
// stall, and a long random run with idle bursts on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import chs_pkg::*;

	localparam int TOTAL_ITEMS = 1050;   // command beats in the whole run
	localparam int QUIET_ITEMS = 150;    // closing stretch with no idling
	localparam int LONG_HOLD   = 400;    // cycles the receiver holds off once
	localparam int DRAIN_LIMIT = 5000;   // cycles allowed for the last results
	localparam int SETTLE      = 80;     // a bit over the longest walk
	localparam int KEY_SPAN    = 1 << KEY_BITS;

	// one result beat as the model sees it
	typedef struct {
		status_t status;
		count_t  stored_count;
	} set_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;    // key
	logic [0:0]          s_tuser;    // cmd
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;    // status, stored_count, zero pad

	// model state: which keys are held and how many
	bit          key_held [0:KEY_SPAN-1];
	int          keys_held;

	// results owed by the block, oldest first
	set_result_t pending_results[$];
	set_result_t oldest_result;

	// up to 256 keys sent with inserts, used to aim deletes and duplicates
	key_t        key_bag[$];

	int          sent_items;
	int          checked_results;
	int          errors;
	int          status_seen [0:7];
	bit          quiet;              // set for the closing stretch, no idling
	bit          long_hold_req;      // asks the receiver for one long hold-off

	chained_hash_set_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// behavioral model
	// ------------------------------------------------------------------

	// a held key occupies exactly one pool node, so the pool runs out
	// when the number of held keys reaches the pool size
	function automatic set_result_t apply_op(input logic op, input key_t key);
		set_result_t r;
		if (op == CMD_INSERT) begin
			if (key_held[key]) begin
				r.status = ST_PRESENT;
			end else if (keys_held >= POOL_SIZE) begin
				r.status = ST_POOL_FULL;
			end else begin
				key_held[key] = 1'b1;
				keys_held++;
				r.status = ST_INSERTED;
			end
		end else begin
			if (key_held[key]) begin
				key_held[key] = 1'b0;
				keys_held--;
				r.status = ST_DELETED;
			end else begin
				r.status = ST_NOT_FOUND;
			end
		end
		r.stored_count = count_t'(keys_held);
		status_seen[r.status]++;
		return r;
	endfunction

	// a random key, either in one bucket or spread out
	function automatic key_t fresh_key(input int focus);
		if (focus >= 0)
			return key_t'(focus + BUCKETS * $urandom_range(0, (KEY_SPAN - 1 - focus) / BUCKETS));
		if ($urandom_range(0, 1) == 0)
			return key_t'($urandom_range(0, 255));
		return key_t'($urandom());
	endfunction

	// deletes mostly hit keys that were inserted, inserts mostly bring new ones
	function automatic key_t pick_key(input logic op, input int focus);
		int bag_pct;
		bag_pct = (op == CMD_DELETE) ? 75 : 15;
		if (key_bag.size() > 0 && $urandom_range(1, 100) <= bag_pct)
			return key_bag[$urandom_range(0, key_bag.size() - 1)];
		return fresh_key(focus);
	endfunction

	// ------------------------------------------------------------------
	// command side: one beat per call, valid stays high between back-to-back
	// beats and only drops during an idle burst
	// ------------------------------------------------------------------
	task automatic send_op(input logic op, input key_t key);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_DATA_W'(key);
		do @(posedge clk); while (!s_tready);
		// the beat went in at this edge
		pending_results.push_back(apply_op(op, key));
		sent_items++;
		if (op == CMD_INSERT) begin
			if (key_bag.size() < 256)
				key_bag.push_back(key);
			else
				key_bag[$urandom_range(0, 255)] = key;
		end
	endtask

	// ------------------------------------------------------------------
	// result side: random stall bursts, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int hold;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				for (hold = 0; hold < LONG_HOLD; hold++)
					@(negedge clk);
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// every result beat is matched against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			checked_results++;
			if (pending_results.size() == 0) begin
				$error("result beat with no command pending: status %0d stored_count %0d",
					m_tdata[2:0], m_tdata[9:3]);
				errors++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (m_tdata[2:0] !== oldest_result.status) begin
					$error("status: expected %0d, got %0d", oldest_result.status, m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[9:3] !== oldest_result.stored_count) begin
					$error("stored_count: expected %0d, got %0d",
						oldest_result.stored_count, m_tdata[9:3]);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// hand-picked edits of two chains: head, middle and tail inserts and
	// unlinks, duplicates, absent keys, key extremes; ends with an empty set
	task automatic test_sorted_chains();
		send_op(CMD_INSERT, 16'd0);       // lowest key into an empty bucket
		send_op(CMD_INSERT, 16'hFFFF);    // highest key, bucket 5
		send_op(CMD_INSERT, 16'd0);       // duplicate insert
		send_op(CMD_DELETE, 16'd7);       // absent, bucket never used
		send_op(CMD_DELETE, 16'd10);      // absent, past the end of a chain
		send_op(CMD_INSERT, 16'd30);      // append to bucket 0
		send_op(CMD_INSERT, 16'd10);      // between 0 and 30
		send_op(CMD_INSERT, 16'd20);      // between 10 and 30
		send_op(CMD_INSERT, 16'd40);      // new tail
		send_op(CMD_DELETE, 16'd25);      // absent, smaller than the chain
		send_op(CMD_DELETE, 16'd20);      // unlink from the middle
		send_op(CMD_DELETE, 16'd0);       // unlink the head
		send_op(CMD_DELETE, 16'd40);      // unlink the tail
		send_op(CMD_DELETE, 16'd40);      // already gone
		send_op(CMD_INSERT, 16'd65525);   // ahead of the highest key
		send_op(CMD_INSERT, 16'd5);       // new head of bucket 5
		send_op(CMD_DELETE, 16'hFFFF);
		send_op(CMD_DELETE, 16'd65525);
		send_op(CMD_DELETE, 16'd5);
		send_op(CMD_DELETE, 16'd10);
		send_op(CMD_DELETE, 16'd30);
		send_op(CMD_DELETE, 16'd30);      // empty chain after the last unlink
	endtask

	// fill every pool node with spread keys, bounce off the full pool,
	// free one node and reuse it, then empty the set
	task automatic test_pool_full();
		key_t live[$];
		key_t key;
		int   idx;
		while (keys_held < POOL_SIZE) begin
			do key = fresh_key(-1); while (key_held[key]);
			live.push_back(key);
			send_op(CMD_INSERT, key);
		end
		do key = fresh_key(-1); while (key_held[key]);
		send_op(CMD_INSERT, key);                          // pool full
		send_op(CMD_INSERT, live[$urandom_range(0, live.size() - 1)]);   // duplicate wins
		idx = $urandom_range(0, live.size() - 1);
		send_op(CMD_DELETE, live[idx]);
		live.delete(idx);
		send_op(CMD_INSERT, key);                          // takes the freed node
		live.push_back(key);
		do key = fresh_key(-1); while (key_held[key]);
		send_op(CMD_INSERT, key);                          // full once more
		while (live.size() > 0) begin
			idx = $urandom_range(0, live.size() - 1);
			send_op(CMD_DELETE, live[idx]);
			live.delete(idx);
		end
	endtask

	// one bucket holds the whole pool, so walks run over all of its nodes
	task automatic test_long_chain();
		key_t chain[$];
		key_t key;
		key_t top_key;
		int   focus;
		int   idx;
		focus   = $urandom_range(0, BUCKETS - 1);
		top_key = 0;
		while (keys_held < POOL_SIZE) begin
			do key = fresh_key(focus); while (key_held[key]);
			chain.push_back(key);
			if (key > top_key)
				top_key = key;
			send_op(CMD_INSERT, key);
		end
		do key = fresh_key(focus); while (key_held[key]);
		send_op(CMD_INSERT, key);           // full after a walk along the chain
		send_op(CMD_INSERT, top_key);       // duplicate at the far end
		send_op(CMD_DELETE, key);           // absent, walks the whole chain
		while (chain.size() > 0) begin
			idx = $urandom_range(0, chain.size() - 1);
			send_op(CMD_DELETE, chain[idx]);
			chain.delete(idx);
		end
	endtask

	// the receiver stops for a long stretch while commands keep coming,
	// so the output register fills and the input stalls
	task automatic test_output_stall();
		logic op;
		long_hold_req = 1'b1;
		repeat (12) begin
			op = ($urandom_range(0, 2) != 0) ? CMD_INSERT : CMD_DELETE;
			send_op(op, pick_key(op, -1));
		end
	endtask

	// phases that grow, drain or churn the set, some aimed at one bucket
	task automatic test_random_mix();
		int   phase_len;
		int   insert_pct;
		int   focus;
		logic op;
		while (sent_items < TOTAL_ITEMS) begin
			phase_len = $urandom_range(16, 80);
			case ($urandom_range(0, 2))
				0: begin
					insert_pct = 85;    // grow toward a full pool
				end
				1: begin
					insert_pct = 20;    // drain
				end
				default: begin
					insert_pct = 50;
				end
			endcase
			focus = ($urandom_range(0, 9) < 3) ? $urandom_range(0, BUCKETS - 1) : -1;
			for (int i = 0; i < phase_len && sent_items < TOTAL_ITEMS; i++) begin
				quiet = (sent_items >= TOTAL_ITEMS - QUIET_ITEMS);
				op = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_DELETE;
				send_op(op, pick_key(op, focus));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		keys_held     = 0;
		sent_items    = 0;
		errors        = 0;
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_sorted_chains();
		test_pool_full();
		test_long_chain();
		test_output_stall();
		test_random_mix();

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && pending_results.size() > 0; n++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() > 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors += pending_results.size();
		end

		$display("tb_top: %0d commands sent, %0d result beats checked, %0d errors",
			sent_items, checked_results, errors);
		$display("tb_top: inserted %0d, present %0d, pool full %0d, deleted %0d, not found %0d",
			status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_POOL_FULL],
			status_seen[ST_DELETED], status_seen[ST_NOT_FOUND]);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
